// ===== hw/rtl/dlim_pkg.sv =====
package dlim_pkg;

	localparam logic [1:0] FUNC_STEP   = 2'd0;
	localparam logic [1:0] FUNC_KIDNAP = 2'd1;
	localparam logic [1:0] FUNC_ESTOP  = 2'd2;

	localparam logic [1:0] MODE_NONE      = 2'd0;
	localparam logic [1:0] MODE_NO_BACKUP = 2'd1;
	localparam logic [1:0] MODE_OVERRIDE  = 2'd2;

	localparam logic [2:0] REG_DRIVE_MODE     = 3'd0;
	localparam logic [2:0] REG_SPEED_NORMAL   = 3'd1;
	localparam logic [2:0] REG_SPEED_OVERRIDE = 3'd2;
	localparam logic [2:0] REG_TURN_LIMIT     = 3'd3;
	localparam logic [2:0] REG_WHEEL_BASE     = 3'd4;
	localparam logic [2:0] REG_BACKUP_STOP    = 3'd5;
	localparam logic [2:0] REG_BACKUP_WARN    = 3'd6;

	localparam int QW    = 16;
	localparam int CNT_W = $clog2(QW);

	typedef struct packed {
		logic [1:0]         drive_mode;
		logic [14:0]        speed_limit_normal;
		logic [14:0]        speed_limit_override;
		logic [14:0]        turn_rate_limit;
		logic [15:0]        wheel_base;
		logic [30:0]        backup_stop_level;
		logic signed [31:0] backup_warn_level;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic prep;
		logic wheel;
		logic mul;
		logic div;
		logic wb;
		logic sel_ang;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic is_step;
		logic scale;
		logic div_last;
	} dp_sts_t;

endpackage

// ===== hw/rtl/dlim_ctrl.sv =====
module dlim_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  dlim_pkg::dp_sts_t sts,
	output dlim_pkg::dp_cmd_t ctl
);
	import dlim_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_PREP  = 3'd1;
	localparam logic [2:0] ST_WHEEL = 3'd2;
	localparam logic [2:0] ST_MUL   = 3'd3;
	localparam logic [2:0] ST_DIV   = 3'd4;
	localparam logic [2:0] ST_WB    = 3'd5;
	localparam logic [2:0] ST_DONE  = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_nxt;
	logic       ang_sel_q;
	logic       out_valid_q;

	always_comb begin
		ctl         = '0;
		ctl.sel_ang = ang_sel_q;
		state_nxt   = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					ctl.load = 1'b1;
					if (sts.is_step) state_nxt = ST_PREP;
				end
			end
			ST_PREP: begin
				ctl.prep  = 1'b1;
				state_nxt = ST_WHEEL;
			end
			ST_WHEEL: begin
				ctl.wheel = 1'b1;
				state_nxt = ST_MUL;
			end
			ST_MUL: begin
				ctl.mul   = 1'b1;
				state_nxt = sts.scale ? ST_DIV : ST_DONE;
			end
			ST_DIV: begin
				ctl.div = 1'b1;
				if (sts.div_last) state_nxt = ST_WB;
			end
			ST_WB: begin
				ctl.wb    = 1'b1;
				state_nxt = ang_sel_q ? ST_DONE : ST_MUL;
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					ctl.emit  = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ang_sel_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (ctl.wheel) ang_sel_q <= 1'b0;
			else if (ctl.wb && !ang_sel_q) ang_sel_q <= 1'b1;
			if (ctl.emit) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

// ===== hw/rtl/dlim_dp.sv =====
module dlim_dp #(
	parameter int ALLOWANCE_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  dlim_pkg::dp_cmd_t  ctl,
	input  dlim_pkg::cfg_t     cfg,
	input  logic [1:0]         func,
	input  logic               cmd_valid,
	input  logic               apply_limits,
	input  logic signed [15:0] lin_cmd,
	input  logic signed [15:0] ang_cmd,
	input  logic signed [15:0] forward_step,
	input  logic               kidnapped,
	input  logic               estop_on,
	output dlim_pkg::dp_sts_t  sts,
	output logic signed [15:0] lin_out,
	output logic signed [15:0] ang_out,
	output logic               motion_enable,
	output logic               backup_low,
	output logic               reverse_blocked
);
	import dlim_pkg::*;

	localparam int SW = ((ALLOWANCE_BITS > 32) ? ALLOWANCE_BITS : 32) + 2;
	localparam logic signed [SW-1:0] AMAX = SW'((64'sd1 <<< (ALLOWANCE_BITS - 1)) - 64'sd1);
	localparam logic signed [SW-1:0] AMIN = ~AMAX;

	// captured word
	logic               cmdv_s1;
	logic               apply_s1;
	logic signed [15:0] lin_in_s1;
	logic signed [15:0] ang_in_s1;
	logic signed [15:0] fstep_s1;

	logic signed [15:0] lin_q;
	logic signed [15:0] ang_q;
	logic signed [31:0] t_q;
	logic               blocked_q;
	logic               low_q;
	logic               limit_q;
	logic [31:0]        m_q;
	logic [25:0]        s_q;
	logic               scale_q;
	logic [41:0]        rem_q;
	logic [QW-1:0]      quo_q;
	logic [CNT_W-1:0]   cnt_q;

	logic signed [ALLOWANCE_BITS-1:0] allow_q;
	logic                             estop_q;
	logic                             was_q;

	logic signed [15:0] lin_out_q;
	logic signed [15:0] ang_out_q;
	logic               wheels_q;
	logic               low_out_q;
	logic               blocked_out_q;

	// prep stage
	logic signed [16:0] ang17;
	logic signed [16:0] tl17;
	logic signed [16:0] ntl17;
	logic signed [15:0] ang_clamp;
	logic               rev_block;
	logic signed [15:0] lin_c;
	logic signed [15:0] ang_c;
	logic signed [32:0] t_full;
	logic signed [SW-1:0] stop_ext;
	logic signed [SW-1:0] top;
	logic signed [SW-1:0] sum;
	logic signed [SW-1:0] sat;
	logic signed [SW-1:0] warn_ext;

	assign ang17 = {ang_in_s1[15], ang_in_s1};
	assign tl17  = $signed({2'b00, cfg.turn_rate_limit});
	assign ntl17 = -tl17;

	always_comb begin
		if (ang17 > tl17) ang_clamp = tl17[15:0];
		else if (ang17 < ntl17) ang_clamp = ntl17[15:0];
		else ang_clamp = ang_in_s1;
	end

	assign rev_block = cmdv_s1 && apply_s1 && (cfg.drive_mode == MODE_NONE) &&
		(allow_q[ALLOWANCE_BITS-1] || (allow_q == '0)) && lin_in_s1[15];

	always_comb begin
		if (!cmdv_s1 || rev_block) begin
			lin_c = '0;
			ang_c = '0;
		end else if (!apply_s1) begin
			lin_c = lin_in_s1;
			ang_c = ang_in_s1;
		end else begin
			lin_c = lin_in_s1;
			ang_c = ang_clamp;
		end
	end

	assign t_full = ang_c * $signed({1'b0, cfg.wheel_base});

	assign stop_ext = $signed({{(SW-31){1'b0}}, cfg.backup_stop_level});
	assign top      = (stop_ext > AMAX) ? AMAX : stop_ext;
	assign sum      = $signed({{(SW-ALLOWANCE_BITS){allow_q[ALLOWANCE_BITS-1]}}, allow_q}) +
		$signed({{(SW-16){fstep_s1[15]}}, fstep_s1});
	assign warn_ext = $signed({{(SW-32){cfg.backup_warn_level[31]}}, cfg.backup_warn_level});

	always_comb begin
		if (sum > top) sat = top;
		else if (sum < AMIN) sat = AMIN;
		else sat = sum;
	end

	// wheel stage
	logic signed [33:0] lin34;
	logic signed [33:0] t34;
	logic signed [33:0] l34;
	logic signed [33:0] r34;
	logic signed [33:0] la34;
	logic signed [33:0] ra34;
	logic [31:0]        m_w;
	logic [14:0]        lim_sel;
	logic [25:0]        s_w;

	assign lin34   = {{7{lin_q[15]}}, lin_q, 11'b0};
	assign t34     = {{2{t_q[31]}}, t_q};
	assign l34     = lin34 - t34;
	assign r34     = lin34 + t34;
	assign la34    = l34[33] ? -l34 : l34;
	assign ra34    = r34[33] ? -r34 : r34;
	assign m_w     = (la34 > ra34) ? la34[31:0] : ra34[31:0];
	assign lim_sel = (cfg.drive_mode == MODE_OVERRIDE) ? cfg.speed_limit_override :
		cfg.speed_limit_normal;
	assign s_w     = {lim_sel, 11'b0};

	// multiply and divide
	logic signed [15:0] x_sel;
	logic [15:0]        x_abs;
	logic [41:0]        prod;
	logic [47:0]        dsh;
	logic [47:0]        rem48;
	logic [47:0]        trial;
	logic               ge;
	logic [15:0]        q_signed;

	assign x_sel    = ctl.sel_ang ? ang_q : lin_q;
	assign x_abs    = x_sel[15] ? (16'd0 - x_sel) : x_sel;
	assign prod     = x_abs * s_q;
	assign dsh      = {16'b0, m_q} << cnt_q;
	assign rem48    = {6'b0, rem_q};
	assign trial    = rem48 - dsh;
	assign ge       = (rem48 >= dsh);
	assign q_signed = x_sel[15] ? (16'd0 - quo_q) : quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			allow_q <= '0;
			estop_q <= 1'b0;
			was_q   <= 1'b0;
		end else begin
			if (ctl.load && (func == FUNC_KIDNAP)) begin
				if (!kidnapped && was_q) allow_q <= '0;
				was_q <= kidnapped;
			end
			if (ctl.load && (func == FUNC_ESTOP)) estop_q <= estop_on;
			if (ctl.prep) allow_q <= sat[ALLOWANCE_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmdv_s1   <= cmd_valid;
			apply_s1  <= apply_limits;
			lin_in_s1 <= lin_cmd;
			ang_in_s1 <= ang_cmd;
			fstep_s1  <= forward_step;
		end
		if (ctl.prep) begin
			lin_q     <= lin_c;
			ang_q     <= ang_c;
			t_q       <= t_full[31:0];
			blocked_q <= rev_block;
			limit_q   <= cmdv_s1 && apply_s1 && !rev_block;
			low_q     <= (cfg.drive_mode == MODE_NONE) && (sat <= warn_ext);
		end
		if (ctl.wheel) begin
			m_q     <= m_w;
			s_q     <= s_w;
			scale_q <= limit_q && (m_w > {6'b0, s_w});
		end
		if (ctl.mul) begin
			rem_q <= prod;
			quo_q <= '0;
			cnt_q <= CNT_W'(QW - 1);
		end
		if (ctl.div) begin
			if (ge) rem_q <= trial[41:0];
			quo_q[cnt_q] <= ge;
			cnt_q        <= cnt_q - 1'b1;
		end
		if (ctl.wb) begin
			if (ctl.sel_ang) ang_q <= q_signed;
			else lin_q <= q_signed;
		end
		if (ctl.emit) begin
			lin_out_q     <= estop_q ? 16'sd0 : lin_q;
			ang_out_q     <= estop_q ? 16'sd0 : ang_q;
			wheels_q      <= !estop_q;
			low_out_q     <= low_q;
			blocked_out_q <= blocked_q;
		end
	end

	assign sts.is_step  = (func == FUNC_STEP);
	assign sts.scale    = scale_q;
	assign sts.div_last = (cnt_q == '0);

	assign lin_out         = lin_out_q;
	assign ang_out         = ang_out_q;
	assign motion_enable   = wheels_q;
	assign backup_low      = low_out_q;
	assign reverse_blocked = blocked_out_q;

endmodule

// ===== hw/rtl/drive_command_safety_limiter.sv =====
// Drive command safety limiter.
// Input channel in_valid/in_stall carries one word per request: a control
// step (func 0), a kidnap status (func 1) or an e-stop request (func 2).
// Kidnap and e-stop words update state in the accept cycle and unused func
// words update none; none gives a result. The block takes the next word in the following cycle.
// A control step gives one result word on out_valid/out_stall. After accept it
// passes through the prep, wheel and multiply states; when speed scaling is
// needed, the shared restoring divider then runs once for each of the two
// scaled velocities. in_stall is high while a step is in work.
// The result sits in an output register; a new word is accepted while it
// waits, and a finished step waits in its last state while out_stall holds an earlier result.
// Configuration is written on cfg_wr_en/cfg_index/cfg_data; the user must write it
// only while the block is idle, which the block does not enforce; indexes beyond the register list are ignored.
// Reset clears the backup allowance, the e-stop and kidnap state, returns
// the registers to their defaults and drops out_valid.
module drive_command_safety_limiter #(
	parameter int ALLOWANCE_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         func,
	input  logic               cmd_valid,
	input  logic               apply_limits,
	input  logic signed [15:0] lin_cmd,
	input  logic signed [15:0] ang_cmd,
	input  logic signed [15:0] forward_step,
	input  logic               kidnapped,
	input  logic               estop_on,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] lin_out,
	output logic signed [15:0] ang_out,
	output logic               motion_enable,
	output logic               backup_low,
	output logic               reverse_blocked
);
	import dlim_pkg::*;

	cfg_t    cfg_q;
	dp_cmd_t ctl;
	dp_sts_t sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.drive_mode           <= MODE_NONE;
			cfg_q.speed_limit_normal   <= 15'd313;
			cfg_q.speed_limit_override <= 15'd471;
			cfg_q.turn_rate_limit      <= 15'd1946;
			cfg_q.wheel_base           <= 16'd239;
			cfg_q.backup_stop_level    <= 31'd13107;
			cfg_q.backup_warn_level    <= 32'sd3277;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_DRIVE_MODE:     cfg_q.drive_mode           <= cfg_data[1:0];
				REG_SPEED_NORMAL:   cfg_q.speed_limit_normal   <= cfg_data[14:0];
				REG_SPEED_OVERRIDE: cfg_q.speed_limit_override <= cfg_data[14:0];
				REG_TURN_LIMIT:     cfg_q.turn_rate_limit      <= cfg_data[14:0];
				REG_WHEEL_BASE:     cfg_q.wheel_base           <= cfg_data[15:0];
				REG_BACKUP_STOP:    cfg_q.backup_stop_level    <= cfg_data[30:0];
				REG_BACKUP_WARN:    cfg_q.backup_warn_level    <= $signed(cfg_data);
				default: begin
				end
			endcase
		end
	end

	dlim_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.ctl       (ctl)
	);

	dlim_dp #(
		.ALLOWANCE_BITS (ALLOWANCE_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctl             (ctl),
		.cfg             (cfg_q),
		.func            (func),
		.cmd_valid       (cmd_valid),
		.apply_limits    (apply_limits),
		.lin_cmd         (lin_cmd),
		.ang_cmd         (ang_cmd),
		.forward_step    (forward_step),
		.kidnapped       (kidnapped),
		.estop_on        (estop_on),
		.sts             (sts),
		.lin_out         (lin_out),
		.ang_out         (ang_out),
		.motion_enable   (motion_enable),
		.backup_low      (backup_low),
		.reverse_blocked (reverse_blocked)
	);

	a_step_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && (func == FUNC_STEP)) |=> in_stall)
		else $error("control step accepted without going busy");

	a_state_word_free: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && (func != FUNC_STEP)) |=> !in_stall)
		else $error("state update word left the block busy");

	a_estop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !motion_enable) |-> (lin_out == 16'sd0 && ang_out == 16'sd0))
		else $error("velocity output nonzero under e-stop");

	a_block_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && reverse_blocked) |-> (lin_out == 16'sd0 && ang_out == 16'sd0))
		else $error("blocked reverse word carries motion");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

import dlim_pkg::*;

typedef struct packed {
	logic [1:0]         func;
	logic               cmd_valid;
	logic               apply_limits;
	logic signed [15:0] lin_cmd;
	logic signed [15:0] ang_cmd;
	logic signed [15:0] forward_step;
	logic               kidnapped;
	logic               estop_on;
} cmd_word_t;

typedef struct packed {
	logic signed [15:0] lin_out;
	logic signed [15:0] ang_out;
	logic               motion_enable;
	logic               backup_low;
	logic               reverse_blocked;
} drive_word_t;

class limiter_shadow;
	bit [1:0]    mode;
	bit [14:0]   spd_normal;
	bit [14:0]   spd_override;
	bit [14:0]   turn_limit;
	bit [15:0]   base;
	longint      stop_level;
	longint      warn_level;
	longint      allowance;
	bit          estop;
	bit          kidnap_prev;
	drive_word_t expected_drive[$];
	int          errors;

	function new();
		mode = MODE_NONE;
		spd_normal = 15'd313;
		spd_override = 15'd471;
		turn_limit = 15'd1946;
		base = 16'd239;
		stop_level = 13107;
		warn_level = 3277;
		allowance = 0;
		estop = 0;
		kidnap_prev = 0;
		errors = 0;
	endfunction

	function void write_reg(logic [2:0] idx, logic [31:0] data);
		case (idx)
			REG_DRIVE_MODE:     mode = data[1:0];
			REG_SPEED_NORMAL:   spd_normal = data[14:0];
			REG_SPEED_OVERRIDE: spd_override = data[14:0];
			REG_TURN_LIMIT:     turn_limit = data[14:0];
			REG_WHEEL_BASE:     base = data[15:0];
			REG_BACKUP_STOP:    stop_level = longint'(data[30:0]);
			REG_BACKUP_WARN:    warn_level = longint'($signed(data));
			default: ;
		endcase
	endfunction

	function void note_word(cmd_word_t w);
		longint lin, ang, tl, t, l, r, m, s, amax, amin;
		bit blocked;
		drive_word_t e;
		amax = 64'sd2147483647;
		amin = -amax - 1;
		lin = 0;
		ang = 0;
		blocked = 0;
		if (w.func == FUNC_KIDNAP) begin
			if (!w.kidnapped && kidnap_prev)
				allowance = 0;
			kidnap_prev = w.kidnapped;
			return;
		end
		if (w.func == FUNC_ESTOP) begin
			estop = w.estop_on;
			return;
		end
		if (w.func != FUNC_STEP)
			return;
		if (w.cmd_valid) begin
			lin = $signed(w.lin_cmd);
			ang = $signed(w.ang_cmd);
			if (w.apply_limits) begin
				tl = longint'(turn_limit);
				if (ang > tl) ang = tl;
				if (ang < -tl) ang = -tl;
				if (mode == MODE_NONE && allowance <= 0 && lin < 0) begin
					lin = 0;
					ang = 0;
					blocked = 1;
				end else begin
					t = ang * longint'(base);
					l = lin * 2048 - t;
					r = lin * 2048 + t;
					if (l < 0) l = -l;
					if (r < 0) r = -r;
					m = (l > r) ? l : r;
					s = longint'((mode == MODE_OVERRIDE) ? spd_override : spd_normal) * 2048;
					if (m > 0 && m > s) begin
						lin = (lin * s) / m;
						ang = (ang * s) / m;
					end
				end
			end
		end
		// allowance moves after the reverse check
		allowance = allowance + longint'($signed(w.forward_step));
		if (allowance > stop_level) allowance = stop_level;
		if (allowance < amin) allowance = amin;
		if (estop) begin
			lin = 0;
			ang = 0;
		end
		e.lin_out = lin[15:0];
		e.ang_out = ang[15:0];
		e.motion_enable = !estop;
		e.backup_low = (mode == MODE_NONE) && (allowance <= warn_level);
		e.reverse_blocked = blocked;
		expected_drive.push_back(e);
	endfunction

	function void compare_field(string name, longint e, longint a);
		if (e != a) begin
			errors++;
			if (errors <= 10)
				$display("mismatch on %s: expected %0d, got %0d", name, e, a);
		end
	endfunction

	function void check_word(drive_word_t a);
		drive_word_t e;
		if (expected_drive.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("result word with nothing expected: lin_out %0d ang_out %0d",
					a.lin_out, a.ang_out);
			return;
		end
		e = expected_drive.pop_front();
		compare_field("lin_out", e.lin_out, a.lin_out);
		compare_field("ang_out", e.ang_out, a.ang_out);
		compare_field("motion_enable", e.motion_enable, a.motion_enable);
		compare_field("backup_low", e.backup_low, a.backup_low);
		compare_field("reverse_blocked", e.reverse_blocked, a.reverse_blocked);
	endfunction

	function int pending();
		return expected_drive.size();
	endfunction

	function void close_out();
		if (expected_drive.size() > 0) begin
			$display("%0d result words never arrived", expected_drive.size());
			errors += expected_drive.size();
		end
	endfunction
endclass

module testbench;
	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam logic [1:0] MODE_SPARE  = 2'd3;
	localparam int CYCLE_LIMIT   = 2000000;
	localparam int SETTLE_CYCLES = 60;
	localparam int HOLD_CYCLES   = 400;

	logic               clk;
	logic               arst_n;
	logic               cfg_wr_en;
	logic [2:0]         cfg_index;
	logic [31:0]        cfg_data;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         func;
	logic               cmd_valid;
	logic               apply_limits;
	logic signed [15:0] lin_cmd;
	logic signed [15:0] ang_cmd;
	logic signed [15:0] forward_step;
	logic               kidnapped;
	logic               estop_on;
	logic               out_valid;
	logic               out_stall;
	logic signed [15:0] lin_out;
	logic signed [15:0] ang_out;
	logic               motion_enable;
	logic               backup_low;
	logic               reverse_blocked;

	limiter_shadow shadow;
	drive_word_t   seen;
	bit            tx_idle;
	bit            rx_idle;
	bit            hold_start;
	int            hold_left;
	int            cycle_count;

	drive_command_safety_limiter dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.func           (func),
		.cmd_valid      (cmd_valid),
		.apply_limits   (apply_limits),
		.lin_cmd        (lin_cmd),
		.ang_cmd        (ang_cmd),
		.forward_step   (forward_step),
		.kidnapped      (kidnapped),
		.estop_on       (estop_on),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.lin_out        (lin_out),
		.ang_out        (ang_out),
		.motion_enable  (motion_enable),
		.backup_low     (backup_low),
		.reverse_blocked(reverse_blocked)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	// receiver side, with a long hold-off on request
	initial begin
		out_stall = 0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_start) begin
				hold_left = HOLD_CYCLES;
				hold_start = 0;
			end
			if (hold_left > 0) begin
				out_stall = 1;
				hold_left--;
			end else
				out_stall = rx_idle && ($urandom_range(99) < 25);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			seen.lin_out = lin_out;
			seen.ang_out = ang_out;
			seen.motion_enable = motion_enable;
			seen.backup_low = backup_low;
			seen.reverse_blocked = reverse_blocked;
			shadow.check_word(seen);
		end
	end

	function automatic logic [15:0] pick16();
		case ($urandom_range(9))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3, 4, 5: return 16'($urandom_range(4096) - 2048);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic cmd_word_t make_word(logic [1:0] f, logic cv, logic ap,
			logic [15:0] lin, logic [15:0] ang, logic [15:0] fwd, logic kid, logic es);
		cmd_word_t w;
		w.func = f;
		w.cmd_valid = cv;
		w.apply_limits = ap;
		w.lin_cmd = lin;
		w.ang_cmd = ang;
		w.forward_step = fwd;
		w.kidnapped = kid;
		w.estop_on = es;
		return w;
	endfunction

	function automatic cmd_word_t random_word();
		cmd_word_t w;
		int pick;
		pick = $urandom_range(99);
		if (pick < 72)
			w.func = FUNC_STEP;
		else if (pick < 84)
			w.func = FUNC_KIDNAP;
		else if (pick < 94)
			w.func = FUNC_ESTOP;
		else
			w.func = FUNC_UNUSED;
		w.cmd_valid = ($urandom_range(9) != 0);
		w.apply_limits = ($urandom_range(4) != 0);
		w.lin_cmd = pick16();
		w.ang_cmd = pick16();
		w.forward_step = pick16();
		w.kidnapped = 1'($urandom_range(1));
		w.estop_on = ($urandom_range(9) < 3);
		return w;
	endfunction

	task automatic send_word(cmd_word_t w);
		@(negedge clk);
		while (tx_idle && $urandom_range(99) < 25) begin
			in_valid = 0;
			@(negedge clk);
		end
		func = w.func;
		cmd_valid = w.cmd_valid;
		apply_limits = w.apply_limits;
		lin_cmd = w.lin_cmd;
		ang_cmd = w.ang_cmd;
		forward_step = w.forward_step;
		kidnapped = w.kidnapped;
		estop_on = w.estop_on;
		in_valid = 1;
		do @(posedge clk); while (in_stall);
		shadow.note_word(w);
	endtask

	task automatic run_words(int n);
		repeat (n) send_word(random_word());
	endtask

	task automatic settle();
		@(negedge clk);
		in_valid = 0;
		while (shadow.pending() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] data);
		@(negedge clk);
		cfg_wr_en = 1;
		cfg_index = idx;
		cfg_data = data;
		@(negedge clk);
		cfg_wr_en = 0;
		shadow.write_reg(idx, data);
	endtask

	task automatic load_regs(logic [1:0] mode, logic [14:0] norm, logic [14:0] ovr,
			logic [14:0] turn, logic [15:0] wb, logic [30:0] stop, logic [31:0] warn);
		settle();
		write_reg(REG_DRIVE_MODE, 32'(mode));
		write_reg(REG_SPEED_NORMAL, 32'(norm));
		write_reg(REG_SPEED_OVERRIDE, 32'(ovr));
		write_reg(REG_TURN_LIMIT, 32'(turn));
		write_reg(REG_WHEEL_BASE, 32'(wb));
		write_reg(REG_BACKUP_STOP, 32'(stop));
		write_reg(REG_BACKUP_WARN, warn);
	endtask

	initial begin
		shadow = new();
		arst_n = 0;
		cfg_wr_en = 0;
		cfg_index = REG_DRIVE_MODE;
		cfg_data = 0;
		in_valid = 0;
		func = FUNC_STEP;
		cmd_valid = 0;
		apply_limits = 0;
		lin_cmd = 0;
		ang_cmd = 0;
		forward_step = 0;
		kidnapped = 0;
		estop_on = 0;
		tx_idle = 1;
		rx_idle = 1;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed words on the reset settings
		send_word(make_word(FUNC_STEP, 0, 1, 16'd1234, -16'sd55, 16'd0, 0, 0));
		send_word(make_word(FUNC_STEP, 1, 0, 16'h7FFF, 16'h8000, 16'd0, 0, 0));
		send_word(make_word(FUNC_STEP, 1, 1, 16'h8000, 16'd100, 16'h7FFF, 0, 0));
		send_word(make_word(FUNC_STEP, 1, 1, 16'h8000, 16'h8000, 16'h8000, 0, 0));
		send_word(make_word(FUNC_STEP, 1, 1, 16'h7FFF, 16'h7FFF, 16'd0, 0, 0));
		send_word(make_word(FUNC_STEP, 1, 1, 16'd0, 16'd0, 16'd0, 0, 0));
		send_word(make_word(FUNC_STEP, 1, 1, 16'd300, 16'd0, 16'd20000, 0, 0));
		send_word(make_word(FUNC_KIDNAP, 0, 0, 16'd0, 16'd0, 16'd0, 1, 0));
		send_word(make_word(FUNC_KIDNAP, 0, 0, 16'd0, 16'd0, 16'd0, 0, 0));
		send_word(make_word(FUNC_STEP, 1, 1, -16'sd5, 16'd40, 16'd0, 0, 0));
		send_word(make_word(FUNC_KIDNAP, 1, 1, 16'd7, 16'd7, 16'd7, 0, 1));
		send_word(make_word(FUNC_ESTOP, 0, 0, 16'd0, 16'd0, 16'd0, 0, 1));
		send_word(make_word(FUNC_STEP, 1, 1, 16'd500, 16'd500, 16'd100, 0, 0));
		send_word(make_word(FUNC_STEP, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 1));
		send_word(make_word(FUNC_ESTOP, 1, 1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 0));
		send_word(make_word(FUNC_UNUSED, 1, 1, 16'h7FFF, 16'h8000, 16'h7FFF, 1, 1));
		send_word(make_word(FUNC_STEP, 1, 1, 16'd1, -16'sd1, 16'd1, 0, 0));
		send_word(make_word(FUNC_STEP, 1, 0, 16'h8000, 16'h7FFF, 16'd1, 0, 0));

		// wide open override
		load_regs(MODE_OVERRIDE, 15'd313, 15'h7FFF, 15'h7FFF, 16'hFFFF,
			31'h7FFFFFFF, 32'h80000000);
		run_words(100);

		// speed, turn and backup levels at their floor
		load_regs(MODE_NO_BACKUP, 15'd0, 15'd0, 15'd0, 16'd1, 31'd0, 32'd0);
		run_words(60);

		// spare mode, no wheel base, no idling, long receiver hold-off
		load_regs(MODE_SPARE, 15'h7FFF, 15'd0, 15'd1000, 16'd0, 31'd50000, 32'hFFFF0000);
		tx_idle = 0;
		rx_idle = 0;
		hold_start = 1;
		run_words(100);
		tx_idle = 1;
		rx_idle = 1;

		load_regs(MODE_NONE, 15'd1000, 15'd2000, 15'd500, 16'd1024, 31'd100000, 32'h7FFFFFFF);
		run_words(120);

		repeat (3) begin
			load_regs(2'($urandom_range(3)), 15'($urandom), 15'($urandom), 15'($urandom),
				16'($urandom), $urandom_range(1) ? 31'($urandom_range(300000)) : 31'($urandom),
				32'($urandom_range(200000)) - 32'd100000);
			run_words(80);
		end

		// drive the allowance well below zero
		load_regs(MODE_NONE, 15'd313, 15'd471, 15'd1946, 16'd239, 31'd0, 32'h80000000);
		tx_idle = 0;
		rx_idle = 0;
		repeat (40)
			send_word(make_word(FUNC_STEP, 1, 1, 16'($urandom) | 16'h8000, pick16(),
				16'h8000, 0, 0));
		send_word(make_word(FUNC_KIDNAP, 0, 0, 16'd0, 16'd0, 16'd0, 1, 0));
		send_word(make_word(FUNC_KIDNAP, 0, 0, 16'd0, 16'd0, 16'd0, 0, 0));
		tx_idle = 1;
		rx_idle = 1;

		load_regs(MODE_NONE, 15'd313, 15'd471, 15'd1946, 16'd239, 31'd13107, 32'd3277);
		run_words(60);

		settle();
		shadow.close_out();
		if (shadow.errors == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end
endmodule
